### rtl/core/assert_macros.svh
// Shared assertion macros for the generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the asynchronous reset is low.
`define LFX_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define LFX_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/lfx_pkg.sv
`default_nettype none

package lfx_pkg;

	localparam int WORD_BITS   = 32;
	localparam int WHEEL_DEPTH = 256;
	localparam int IDX_BITS    = $clog2(WHEEL_DEPTH);

	typedef logic        [WORD_BITS-1:0] word_t;
	typedef logic signed [WORD_BITS-1:0] sword_t;
	typedef logic        [IDX_BITS-1:0]  idx_t;

	// Lags behind the current position.
	localparam idx_t LAG_A = idx_t'(11);
	localparam idx_t LAG_B = idx_t'(29);
	localparam idx_t LAG_X = idx_t'(17);

	localparam word_t TOP_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

	// Command codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_GEN  = 1'b1;

	typedef struct packed {
		logic  valid;
		logic  func;
		word_t seed_word;
		idx_t  pos;
	} stage_t;

	typedef struct packed {
		logic en;
		idx_t addr_a;
		idx_t addr_b;
		idx_t addr_x;
	} wheel_rd_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} wheel_wr_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t x;
	} wheel_data_t;

endpackage

`default_nettype wire

### rtl/core/lfx_cmd_if.sv
`default_nettype none

interface lfx_cmd_if;
	logic          valid;
	logic          ready;
	logic          func;
	lfx_pkg::word_t seed_word;

	modport source (output valid, output func, output seed_word, input ready);
	modport sink   (input valid, input func, input seed_word, output ready);
endinterface

`default_nettype wire

### rtl/core/lfx_rnd_if.sv
`default_nettype none

interface lfx_rnd_if;
	logic            valid;
	logic            ready;
	lfx_pkg::word_t  random_word;
	lfx_pkg::sword_t uniform_fraction;

	modport source (output valid, output random_word, output uniform_fraction, input ready);
	modport sink   (input valid, input random_word, input uniform_fraction, output ready);
endinterface

`default_nettype wire

### rtl/core/lfx_wheel.sv
`default_nettype none

// Wheel storage: two identical banks share every write; one gives two lagged taps
// and the other the third. Read data is registered and held between reads.
module lfx_wheel (
	input  wire                  clk,
	input  lfx_pkg::wheel_rd_t   rd,
	input  lfx_pkg::wheel_wr_t   wr,
	output lfx_pkg::wheel_data_t data
);

	lfx_pkg::word_t bank_ab [lfx_pkg::WHEEL_DEPTH];
	lfx_pkg::word_t bank_x  [lfx_pkg::WHEEL_DEPTH];

	lfx_pkg::word_t a_q;
	lfx_pkg::word_t b_q;
	lfx_pkg::word_t x_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			bank_ab[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			a_q <= bank_ab[rd.addr_a];
			b_q <= bank_ab[rd.addr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			bank_x[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			x_q <= bank_x[rd.addr_x];
		end
	end

	assign data = '{a: a_q, b: b_q, x: x_q};

endmodule

`default_nettype wire

### rtl/core/lfx_mix.sv
`default_nettype none

// Second stage: forms the lagged sum, writes it (or a load's seed word) back to
// the wheel and holds the result beat in the output register until it is taken.
module lfx_mix (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lfx_pkg::stage_t       stage,
	input  lfx_pkg::wheel_data_t  data,
	output lfx_pkg::wheel_wr_t    wr,
	output logic                  take,
	lfx_rnd_if.source             rnd
);

	lfx_pkg::word_t sum;
	lfx_pkg::word_t word;
	logic           gen;
	logic           valid_s2;
	lfx_pkg::word_t word_s2;

	assign sum  = data.a + data.b;
	assign word = sum ^ data.x;
	assign gen  = (stage.func == lfx_pkg::FUNC_GEN);

	// A load never needs the output register; a generate needs it free or emptying.
	assign take = stage.valid && (!gen || !valid_s2 || rnd.ready);

	always_comb begin
		wr.en   = take;
		wr.addr = stage.pos;
		wr.data = gen ? sum : stage.seed_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take && gen) begin
			valid_s2 <= 1'b1;
		end else if (rnd.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && gen) begin
			word_s2 <= word;
		end
	end

	assign rnd.valid            = valid_s2;
	assign rnd.random_word      = word_s2;
	assign rnd.uniform_fraction = lfx_pkg::sword_t'(word_s2 ^ lfx_pkg::TOP_BIT);

endmodule

`default_nettype wire

### rtl/core/lagged_fibonacci_xor_generator_unit.sv
// Lagged Fibonacci random word source with an XOR output tap.
// The cmd channel carries one beat per operation: func selects a load, which
// writes seed_word into the wheel at the current position, or a generate,
// which adds the entries 11 and 29 places back, stores the sum at the
// position and returns the sum XOR the entry 17 places back. Both advance
// the 8-bit position, which wraps at 256.
// The rnd channel returns one beat per generate and none per load: the raw
// random_word and uniform_fraction, a Q1.31 value in [-1,1) that is the
// same word with its top bit inverted.
// A command passes through the stage-one register, with the wheel taps read
// into registers beside it, and then the output register that drives
// rnd.valid. One beat is accepted every cycle while the receiver keeps up; the
// single wheel read and write per beat, on two mirrored banks, sets that rate.
// Reset clears the position to zero and empties the pipeline. The wheel is
// not cleared: all 256 entries must be loaded before the first generate.
// When the receiver stalls, the result beat holds in the output register,
// one more generate may wait behind it, and then cmd.ready drops.
`default_nettype none

`include "assert_macros.svh"

module lagged_fibonacci_xor_generator_unit (
	input  wire         clk,
	input  wire         arst_n,
	lfx_cmd_if.sink     cmd,
	lfx_rnd_if.source   rnd
);

	lfx_pkg::idx_t        pos_q;
	logic                 valid_s1;
	logic                 func_s1;
	lfx_pkg::word_t       seed_s1;
	lfx_pkg::idx_t        pos_s1;
	logic                 accept;
	logic                 take;
	lfx_pkg::stage_t      stage;
	lfx_pkg::wheel_rd_t   rd;
	lfx_pkg::wheel_wr_t   wr;
	lfx_pkg::wheel_data_t data;

	// Stage one is free, or empties at this same edge.
	assign cmd.ready = !valid_s1 || take;
	assign accept    = cmd.valid && cmd.ready;

	// The taps are read as the beat is accepted. Lags of at least 11 mean the
	// one write still in flight never lands on an address read here.
	always_comb begin
		rd.en     = accept;
		rd.addr_a = pos_q - lfx_pkg::LAG_A;
		rd.addr_b = pos_q - lfx_pkg::LAG_B;
		rd.addr_x = pos_q - lfx_pkg::LAG_X;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q <= pos_q + lfx_pkg::idx_t'(1);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= cmd.func;
			seed_s1 <= cmd.seed_word;
			pos_s1  <= pos_q;
		end
	end

	assign stage = '{valid: valid_s1, func: func_s1, seed_word: seed_s1, pos: pos_s1};

	lfx_wheel u_wheel (
		.clk  (clk),
		.rd   (rd),
		.wr   (wr),
		.data (data)
	);

	lfx_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.stage  (stage),
		.data   (data),
		.wr     (wr),
		.take   (take),
		.rnd    (rnd)
	);

	`LFX_ASSERT(pos_step, clk, arst_n, (pos_q == lfx_pkg::idx_t'($past(pos_q) + ($past(accept) ? 8'd1 : 8'd0)) || $past(!arst_n)), "position did not follow accepted beats")
	`LFX_ASSERT(wr_needs_stage, clk, arst_n, (wr.en |-> (valid_s1 && wr.addr == pos_s1)), "wheel written without a beat in stage one")
	`LFX_ASSERT(gen_waits, clk, arst_n, ((valid_s1 && func_s1 == lfx_pkg::FUNC_GEN && rnd.valid && !rnd.ready) |=> (valid_s1 && $stable(pos_s1))), "stalled generate left stage one")

endmodule

`default_nettype wire
